// File: hdl/lea_block_cipher_defines.svh
// Assertion macros used by the cipher control module.
`ifndef LEA_BLOCK_CIPHER_DEFINES_SVH
`define LEA_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define LEA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define LEA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lea_pkg.sv
// Types, constants and helper functions of the LEA cipher core.
`default_nettype none
package lea_pkg;

  localparam int unsigned LEA_MAX_ROUNDS = 32;
  localparam int unsigned RK_WORDS = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY01  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY23  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY45  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY67  = 3'd4;

  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;

  localparam logic FUNC_ENC = 1'b0;

  localparam logic [31:0] DELTA [8] = '{
    32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec,
    32'h715ea49e, 32'hc785da0a, 32'he04ef22a, 32'he5c40957
  };

  localparam logic [4:0] KS_ROT [RK_WORDS] = '{5'd1, 5'd3, 5'd6, 5'd11, 5'd13, 5'd17};

  typedef struct packed {
    logic load;
    logic exp_step;
    logic prep;
    logic run_step;
    logic out_load;
  } lea_cmd_t;

  typedef struct packed {
    logic last;
  } lea_sts_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} >> n;
    return w[31:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/lea_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module lea_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hdl/lea_ctrl.sv
// Sequencer of the LEA core: key expansion, round loop and result hand-off.
`default_nettype none
`include "lea_block_cipher_defines.svh"
module lea_ctrl
  import lea_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  output      lea_cmd_t             cmd_o,
  input  wire lea_sts_t             sts_i
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXPAND = 5'b00010,
    S_PREP   = 5'b00100,
    S_RUN    = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;
  logic   out_valid_q, out_valid_d;
  logic   cfg_clear;

  assign cfg_clear = cfg_we_i && (cfg_idx_i <= CFG_KEY67);

  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ready_q ? S_PREP : S_EXPAND;
        end
      end
      S_EXPAND: begin
        cmd_o.exp_step = 1'b1;
        if (sts_i.last) begin
          ready_d = 1'b1;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_RUN;
      end
      S_RUN: begin
        cmd_o.run_step = 1'b1;
        if (sts_i.last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (cfg_clear) begin
      ready_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `LEA_ASSERT_NXT(a_cfg_clears_ready, cfg_clear, !ready_q, "key ready survived a config write")
  `LEA_ASSERT_NXT(a_run_to_finish, (state_q == S_RUN) && sts_i.last, state_q == S_FINISH, "round loop did not end")
  `LEA_ASSERT_IMP(a_expand_not_ready, state_q == S_EXPAND, !ready_q, "expanding while keys ready")
  `LEA_ASSERT_NXT(a_out_load_valid, cmd_o.out_load, out_valid_q, "result load lost")

endmodule
`default_nettype wire

// File: hdl/lea_dpath.sv
// Datapath of the LEA core: config registers, key schedule, rounds, result.
`default_nettype none
module lea_dpath
  import lea_pkg::*;
#(
  parameter int unsigned MaxRounds = LEA_MAX_ROUNDS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  func_i,
  input  wire logic [31:0]           block_in_0_i,
  input  wire logic [31:0]           block_in_1_i,
  input  wire logic [31:0]           block_in_2_i,
  input  wire logic [31:0]           block_in_3_i,
  output      logic [31:0]           block_out_0_o,
  output      logic [31:0]           block_out_1_o,
  output      logic [31:0]           block_out_2_o,
  output      logic [31:0]           block_out_3_o,
  input  wire lea_cmd_t              cmd_i,
  output      lea_sts_t              sts_o
);

  localparam int unsigned CW = $clog2(MaxRounds);
  localparam int unsigned RKW = 32 * RK_WORDS;

  logic [1:0]        mode_q;
  logic [63:0]       key_q [4];
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [2:0]        m6_q, m6_d;
  logic [31:0]       t_q [8];
  logic [31:0]       t_d [8];
  logic [31:0]       x_q [4];
  logic [31:0]       x_d [4];
  logic [31:0]       y_q [4];
  logic              func_q;
  logic [CW-1:0]     nm1;
  logic [CW-1:0]     rd_cnt;
  logic [CW-1:0]     raddr;
  logic [RKW-1:0]    rk_wdata;
  logic [RKW-1:0]    rk_rdata;
  logic [31:0]       rk [RK_WORDS];
  logic [31:0]       delta;
  logic [2:0]        kbase;
  logic [2:0]        kidx [RK_WORDS];
  logic [31:0]       knew [RK_WORDS];
  logic [31:0]       e0, e1, e2, d1, d2, d3;

  always_comb begin
    case (mode_q)
      MODE_128: nm1 = CW'(23);
      MODE_192: nm1 = CW'(27);
      default:  nm1 = CW'(MaxRounds - 1);
    endcase
  end

  assign sts_o.last = (cnt_q == nm1);

  // key schedule, one round per cycle
  always_comb begin
    case (mode_q)
      MODE_128: delta = DELTA[{1'b0, cnt_q[1:0]}];
      MODE_192: delta = DELTA[m6_q];
      default:  delta = DELTA[cnt_q[2:0]];
    endcase
    kbase = 3'({cnt_q[2:0], 2'b00} + {cnt_q[2:0], 1'b0});
    for (int j = 0; j < RK_WORDS; j++) begin
      kidx[j] = ((mode_q == MODE_128) || (mode_q == MODE_192)) ? 3'(j) : 3'(kbase + 3'(j));
      knew[j] = rotl32(t_q[kidx[j]] + rotl32(delta, 5'(cnt_q + CW'(j))), KS_ROT[j]);
    end
    for (int k = 0; k < 8; k++) begin
      t_d[k] = t_q[k];
    end
    if (cmd_i.load) begin
      for (int k = 0; k < 4; k++) begin
        t_d[2*k]   = key_q[k][31:0];
        t_d[2*k+1] = key_q[k][63:32];
      end
    end else if (cmd_i.exp_step) begin
      if (mode_q == MODE_128) begin
        for (int j = 0; j < 4; j++) begin
          t_d[j] = knew[j];
        end
      end else begin
        for (int j = 0; j < RK_WORDS; j++) begin
          t_d[kidx[j]] = knew[j];
        end
      end
    end
    if (mode_q == MODE_128) begin
      rk_wdata = {knew[1], knew[3], knew[1], knew[2], knew[1], knew[0]};
    end else begin
      rk_wdata = {knew[5], knew[4], knew[3], knew[2], knew[1], knew[0]};
    end
  end

  // round key fetch addresses the next round, so its registered read is ready when that round runs
  assign rd_cnt = cmd_i.prep ? '0 : CW'(cnt_q + 1'b1);
  assign raddr  = (func_q == FUNC_ENC) ? rd_cnt : CW'(nm1 - rd_cnt);

  lea_ram #(
    .Width (RKW),
    .Depth (MaxRounds)
  ) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exp_step),
    .waddr_i (cnt_q),
    .wdata_i (rk_wdata),
    .raddr_i (raddr),
    .rdata_o (rk_rdata)
  );

  always_comb begin
    for (int j = 0; j < RK_WORDS; j++) begin
      rk[j] = rk_rdata[32*j +: 32];
    end
    e0 = rotl32((x_q[0] ^ rk[0]) + (x_q[1] ^ rk[1]), 5'd9);
    e1 = rotr32((x_q[1] ^ rk[2]) + (x_q[2] ^ rk[3]), 5'd5);
    e2 = rotr32((x_q[2] ^ rk[4]) + (x_q[3] ^ rk[5]), 5'd3);
    d1 = (rotr32(x_q[0], 5'd9) - (x_q[3] ^ rk[0])) ^ rk[1];
    d2 = (rotl32(x_q[1], 5'd5) - (d1 ^ rk[2])) ^ rk[3];
    d3 = (rotl32(x_q[2], 5'd3) - (d2 ^ rk[4])) ^ rk[5];
    for (int j = 0; j < 4; j++) begin
      x_d[j] = x_q[j];
    end
    if (cmd_i.load) begin
      x_d[0] = block_in_0_i;
      x_d[1] = block_in_1_i;
      x_d[2] = block_in_2_i;
      x_d[3] = block_in_3_i;
    end else if (cmd_i.run_step) begin
      if (func_q == FUNC_ENC) begin
        x_d[0] = e0;
        x_d[1] = e1;
        x_d[2] = e2;
        x_d[3] = x_q[0];
      end else begin
        x_d[0] = x_q[3];
        x_d[1] = d1;
        x_d[2] = d2;
        x_d[3] = d3;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    m6_d  = m6_q;
    if (cmd_i.load || cmd_i.prep) begin
      cnt_d = '0;
      m6_d  = '0;
    end else if (cmd_i.exp_step || cmd_i.run_step) begin
      cnt_d = CW'(cnt_q + 1'b1);
      m6_d  = (m6_q == 3'd5) ? 3'd0 : 3'(m6_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_128;
      for (int k = 0; k < 4; k++) begin
        key_q[k] <= '0;
      end
      cnt_q <= '0;
      m6_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      m6_q  <= m6_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:  mode_q   <= cfg_data_i[1:0];
          CFG_KEY01: key_q[0] <= cfg_data_i;
          CFG_KEY23: key_q[1] <= cfg_data_i;
          CFG_KEY45: key_q[2] <= cfg_data_i;
          CFG_KEY67: key_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 8; k++) begin
      t_q[k] <= t_d[k];
    end
    for (int j = 0; j < 4; j++) begin
      x_q[j] <= x_d[j];
    end
    if (cmd_i.load) begin
      func_q <= func_i;
    end
    if (cmd_i.out_load) begin
      for (int j = 0; j < 4; j++) begin
        y_q[j] <= x_q[j];
      end
    end
  end

  assign block_out_0_o = y_q[0];
  assign block_out_1_o = y_q[1];
  assign block_out_2_o = y_q[2];
  assign block_out_3_o = y_q[3];

endmodule
`default_nettype wire

// File: hdl/lea_block_cipher.sv
// Top level of the LEA block cipher core.
//
//  channel   direction  handshake                 payload
//  in        sink       in_valid_i / in_stall_o   func_i, block_in_0..3_i
//  out       source     out_valid_o / out_stall_i block_out_0..3_o
//  config    sink       cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A transaction runs n rounds from accept to result, n = 24, 28 or 32 by key size,
// on the single round unit that does one round per clock.
// After reset or a mode/key config write, the next transaction first expands the keys.
// The round key RAM is read for the next round; its registered read needs the PREP step.
// A new transaction is accepted while the previous result waits in the output register.
// Reset clears control state and config registers; round keys are rebuilt on demand.
`default_nettype none
module lea_block_cipher
  import lea_pkg::*;
#(
  parameter int unsigned MaxRounds = LEA_MAX_ROUNDS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic                  func_i,
  input  wire logic [31:0]           block_in_0_i,
  input  wire logic [31:0]           block_in_1_i,
  input  wire logic [31:0]           block_in_2_i,
  input  wire logic [31:0]           block_in_3_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [31:0]           block_out_0_o,
  output      logic [31:0]           block_out_1_o,
  output      logic [31:0]           block_out_2_o,
  output      logic [31:0]           block_out_3_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  lea_cmd_t cmd;
  lea_sts_t sts;

  lea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lea_dpath #(
    .MaxRounds (MaxRounds)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .func_i        (func_i),
    .block_in_0_i  (block_in_0_i),
    .block_in_1_i  (block_in_1_i),
    .block_in_2_i  (block_in_2_i),
    .block_in_3_i  (block_in_3_i),
    .block_out_0_o (block_out_0_o),
    .block_out_1_o (block_out_1_o),
    .block_out_2_o (block_out_2_o),
    .block_out_3_o (block_out_3_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
`default_nettype wire
